[design/jhs_pkg.sv]
// jhs_pkg: shared types, codes and defaults for the joystick hysteresis smoother
// used by the channel interfaces and by joystick_hysteresis_smoother_core
// no dependencies
package jhs_pkg;

    localparam int STICK_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // configuration registers are all 16 bits wide
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GAIN_W    = 16;

    localparam logic [CFG_W-1:0] ENTER_RST = 16'd9000;
    localparam logic [CFG_W-1:0] EXIT_RST  = 16'd7000;
    localparam logic [CFG_W-1:0] GAIN_RST  = 16'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTER = 2'd0,
        CFG_EXIT  = 2'd1,
        CFG_GAIN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_MOVE = 2'd1,
        HEAD_STOP = 2'd2
    } t_head_cmd;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_RUN  = 2'd1,
        ROT_STOP = 2'd2
    } t_rot_cmd;

endpackage

[design/jhs_in_if.sv]
// jhs_in_if: input channel carrying one stick sample (both sticks, both buttons)
// depends on jhs_pkg for the default stick width
interface jhs_in_if
    import jhs_pkg::*;
#(
    parameter int STICK_BITS = STICK_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [STICK_BITS-1:0] left_x;
    logic signed [STICK_BITS-1:0] left_y;
    logic signed [STICK_BITS-1:0] right_x;
    logic signed [STICK_BITS-1:0] right_y;
    logic                         right_button;
    logic                         left_button;

    modport source (
        output valid, left_x, left_y, right_x, right_y, right_button, left_button,
        input  ready
    );
    modport sink (
        input  valid, left_x, left_y, right_x, right_y, right_button, left_button,
        output ready
    );
endinterface

[design/jhs_out_if.sv]
// jhs_out_if: result channel carrying head, walk and rotate commands
// depends on jhs_pkg for command types and the default stick width
interface jhs_out_if
    import jhs_pkg::*;
#(
    parameter int STICK_BITS = STICK_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    t_head_cmd                    head_cmd;
    logic signed [STICK_BITS-1:0] head_x;
    logic signed [STICK_BITS-1:0] head_y;
    logic                         walk_cmd;
    logic signed [STICK_BITS-1:0] walk_x;
    logic signed [STICK_BITS-1:0] walk_y;
    t_rot_cmd                     rotate_cmd;
    logic                         rotate_dir;

    modport source (
        output valid, head_cmd, head_x, head_y, walk_cmd, walk_x, walk_y,
               rotate_cmd, rotate_dir,
        input  ready
    );
    modport sink (
        input  valid, head_cmd, head_x, head_y, walk_cmd, walk_x, walk_y,
               rotate_cmd, rotate_dir,
        output ready
    );
endinterface

[design/joystick_hysteresis_smoother_core.sv]
// joystick_hysteresis_smoother_core: dead zone hysteresis and exponential smoothing of
// two sticks, plus button rotation commands; one result per sample
// depends on jhs_pkg, jhs_in_if and jhs_out_if

// One sample goes in and one command result comes out, when the output is free. A sample
// lands in an input register; once it moves on, the threshold compares and
// four exponential-average updates (one 17 x (STICK_BITS+FRACTION_BITS+1) multiply per
// axis) run between that register and the result register, and the smoothed state is
// written back in the same cycle. Both registers advance together, so a new sample is
// taken every cycle while the result side keeps taking transfers. Configuration writes
// take effect at once; make them while no sample is in flight.
module joystick_hysteresis_smoother_core
    import jhs_pkg::*;
#(
    parameter int STICK_BITS    = STICK_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    jhs_in_if.sink               i_in,
    jhs_out_if.source            o_out
);

    localparam int SW    = STICK_BITS + FRACTION_BITS;
    localparam int PW    = SW + GAIN_W + 2;
    localparam int CMP_W = (STICK_BITS + 1 > CFG_W) ? STICK_BITS + 1 : CFG_W;

    function automatic logic [CMP_W-1:0] mag_of(input logic signed [STICK_BITS-1:0] v);
        logic [STICK_BITS:0] ext;
        ext = {v[STICK_BITS-1], v};
        if (ext[STICK_BITS]) begin
            ext = ~ext + 1'b1;
        end
        return CMP_W'(ext);
    endfunction

    // s += (gain * ((x << FRACTION_BITS) - s)) >>> GAIN_W
    function automatic logic signed [SW-1:0] ema(
        input logic signed [SW-1:0]         s,
        input logic signed [STICK_BITS-1:0] x,
        input logic [GAIN_W-1:0]            g
    );
        logic signed [SW:0]   diff;
        logic signed [PW-1:0] prod;
        diff = $signed({x[STICK_BITS-1], x, {FRACTION_BITS{1'b0}}}) - $signed({s[SW-1], s});
        prod = $signed({1'b0, g}) * diff;
        return s + $signed(prod[GAIN_W +: SW]);
    endfunction

    // configuration
    logic [CFG_W-1:0] r_enter;
    logic [CFG_W-1:0] r_exit;
    logic [CFG_W-1:0] r_gain;

    // input register
    logic                         r_in_valid;
    logic signed [STICK_BITS-1:0] r_lx, r_ly, r_rx, r_ry;
    logic                         r_rb, r_lb;

    // state
    logic                 r_walk_active, r_head_active, r_rot_active;
    logic signed [SW-1:0] r_sm_lx, r_sm_ly, r_sm_rx, r_sm_ry;

    // result register
    logic                         r_out_valid;
    t_head_cmd                    r_head_cmd;
    logic signed [STICK_BITS-1:0] r_head_x, r_head_y;
    logic                         r_walk_cmd;
    logic signed [STICK_BITS-1:0] r_walk_x, r_walk_y;
    t_rot_cmd                     r_rot_cmd;
    logic                         r_rot_dir;

    // next values
    logic                 adv;
    logic                 right_hit, left_hit, left_clear;
    logic                 n_walk_active, n_head_active, n_rot_active;
    logic signed [SW-1:0] n_sm_lx, n_sm_ly, n_sm_rx, n_sm_ry;
    t_head_cmd            n_head_cmd;
    t_rot_cmd             n_rot_cmd;
    logic                 n_rot_dir;
    logic [CMP_W-1:0]     enter_ext, exit_ext;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_comb begin
        enter_ext  = CMP_W'(r_enter);
        exit_ext   = CMP_W'(r_exit);
        right_hit  = (mag_of(r_rx) > enter_ext) || (mag_of(r_ry) > enter_ext);
        left_hit   = (mag_of(r_lx) > enter_ext) || (mag_of(r_ly) > enter_ext);
        left_clear = (mag_of(r_lx) < exit_ext) && (mag_of(r_ly) < exit_ext);

        n_sm_lx = ema(r_sm_lx, r_lx, r_gain);
        n_sm_ly = ema(r_sm_ly, r_ly, r_gain);
        n_sm_rx = r_sm_rx;
        n_sm_ry = r_sm_ry;

        n_head_cmd    = HEAD_NONE;
        n_head_active = r_head_active;
        if (right_hit) begin
            n_sm_rx       = ema(r_sm_rx, r_rx, r_gain);
            n_sm_ry       = ema(r_sm_ry, r_ry, r_gain);
            n_head_cmd    = HEAD_MOVE;
            n_head_active = 1'b1;
        end else if (r_head_active) begin
            n_head_cmd    = HEAD_STOP;
            n_head_active = 1'b0;
        end

        // enter test wins over exit when thresholds cross
        n_walk_active = r_walk_active;
        if (left_hit) begin
            n_walk_active = 1'b1;
        end else if (left_clear) begin
            n_walk_active = 1'b0;
        end

        n_rot_cmd    = ROT_NONE;
        n_rot_dir    = 1'b0;
        n_rot_active = r_rot_active;
        if (r_rb != r_lb) begin
            n_rot_cmd    = ROT_RUN;
            n_rot_dir    = r_rb;
            n_rot_active = 1'b1;
        end else if (r_rot_active) begin
            n_rot_cmd    = ROT_STOP;
            n_rot_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter <= ENTER_RST;
            r_exit  <= EXIT_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENTER: r_enter <= i_cfg_data;
                CFG_EXIT:  r_exit  <= i_cfg_data;
                CFG_GAIN:  r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_walk_active <= 1'b0;
            r_head_active <= 1'b0;
            r_rot_active  <= 1'b0;
            r_sm_lx       <= '0;
            r_sm_ly       <= '0;
            r_sm_rx       <= '0;
            r_sm_ry       <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_walk_active <= n_walk_active;
                r_head_active <= n_head_active;
                r_rot_active  <= n_rot_active;
                r_sm_lx       <= n_sm_lx;
                r_sm_ly       <= n_sm_ly;
                r_sm_rx       <= n_sm_rx;
                r_sm_ry       <= n_sm_ry;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_lx <= i_in.left_x;
            r_ly <= i_in.left_y;
            r_rx <= i_in.right_x;
            r_ry <= i_in.right_y;
            r_rb <= i_in.right_button;
            r_lb <= i_in.left_button;
        end
        if (adv) begin
            r_head_cmd <= n_head_cmd;
            r_head_x   <= right_hit ? n_sm_rx[SW-1 -: STICK_BITS] : '0;
            r_head_y   <= right_hit ? n_sm_ry[SW-1 -: STICK_BITS] : '0;
            r_walk_cmd <= n_walk_active;
            r_walk_x   <= n_walk_active ? n_sm_lx[SW-1 -: STICK_BITS] : '0;
            r_walk_y   <= n_walk_active ? n_sm_ly[SW-1 -: STICK_BITS] : '0;
            r_rot_cmd  <= n_rot_cmd;
            r_rot_dir  <= n_rot_dir;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.head_cmd   = r_head_cmd;
    assign o_out.head_x     = r_head_x;
    assign o_out.head_y     = r_head_y;
    assign o_out.walk_cmd   = r_walk_cmd;
    assign o_out.walk_x     = r_walk_x;
    assign o_out.walk_y     = r_walk_y;
    assign o_out.rotate_cmd = r_rot_cmd;
    assign o_out.rotate_dir = r_rot_dir;

`ifndef SYNTHESIS
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register empty after a processed sample");

    a_rot_stop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_rot_cmd == ROT_STOP) |-> r_rot_active)
        else $error("rotate stop issued while rotation idle");

    a_head_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_head_cmd == HEAD_STOP) |=> !r_head_active)
        else $error("head still active after stop");

    a_gain_zero_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_gain == '0) |=> (r_sm_lx == $past(r_sm_lx) && r_sm_ly == $past(r_sm_ly)))
        else $error("left smoothing moved with zero gain");
`endif

endmodule
